>>> rtl/core/scpc_pkg.sv
// Shared types and constants for the scan point cluster centroid block.
package scpc_pkg;

    localparam int CoordW   = 14;
    localparam int SumW     = 25;
    localparam int CountW   = 11;
    localparam int DistW    = 15;
    localparam int IdxW     = 3;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam logic [CountW-1:0] CountMax   = 11'd2047;
    localparam logic [CountW-1:0] MinMembers = 11'd2;
    localparam logic [DistW-1:0]  JoinReset  = 15'd150;

    localparam int DivSteps = SumW;
    localparam int DivCntW  = 5;

    // One unit of work for the back end: a centroid to compute or a scan end marker.
    typedef struct packed {
        logic              is_marker;
        logic [IdxW-1:0]   index;
        logic [IdxW-1:0]   total;
        logic [CountW-1:0] count;
        logic [SumW-1:0]   sum_x;
        logic [SumW-1:0]   sum_y;
    } t_job;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } t_back_state;

endpackage

>>> rtl/core/scan_point_cluster_centroids.sv
// Top level of the scan point cluster centroid block: stream ports, register port, wiring.
//
// Points of one scan enter in angular order; consecutive points within join_distance
// (Manhattan, from the object's seed) form an object, and each closed object of three or
// more points yields its centroid, up to MAX_OBJECTS-1 per scan, followed by an end marker
// on the scan's last request. A point request is taken whenever the four-entry job queue has
// room; a request that yields two results holds the input until its end marker is queued.
// Each centroid passes through the back end as queue pop, 25 steps of the shared bit-serial
// divider for both coordinates and result load, an end marker as pop and load alone; one job
// is finished before the next is popped, so the divider sets the sustained rate, with bursts of
// up to four jobs absorbed by the queue. No clearing pass follows reset.
module scan_point_cluster_centroids #(
    parameter int MAX_OBJECTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // point request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // point_x[13:0], point_y[27:14], zero[31:28]
    input  logic        s_axis_tuser,   // has_point
    input  logic        s_axis_tlast,   // last_in_scan
    // result request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // centroid_x[13:0], centroid_y[27:14],
                                        // object_index[30:28], object_total[33:31], zero[39:34]
    output logic        m_axis_tuser,   // object_valid
    output logic        m_axis_tlast,   // scan_done
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scpc_pkg::*;

    logic [DistW-1:0]  r_join_distance;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_push;
    logic              w_pop;
    t_job              w_push_job;
    t_job              w_head_job;
    logic [CoordW-1:0] w_cx;
    logic [CoordW-1:0] w_cy;
    logic [IdxW-1:0]   w_idx;
    logic [IdxW-1:0]   w_total;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-DistW){1'b0}}, r_join_distance};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_join_distance <= JoinReset;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_join_distance <= pwdata[DistW-1:0];
        end
    end

    scpc_front #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_point_x       (s_axis_tdata[CoordW-1:0]),
        .i_point_y       (s_axis_tdata[2*CoordW-1:CoordW]),
        .i_has_point     (s_axis_tuser),
        .i_last_in_scan  (s_axis_tlast),
        .i_join_distance (r_join_distance),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_push_job      (w_push_job)
    );

    scpc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_head_job (w_head_job),
        .o_empty    (w_q_empty),
        .o_full     (w_q_full)
    );

    scpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_job     (w_head_job),
        .i_q_empty      (w_q_empty),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_centroid_x   (w_cx),
        .o_centroid_y   (w_cy),
        .o_object_index (w_idx),
        .o_object_valid (m_axis_tuser),
        .o_scan_done    (m_axis_tlast),
        .o_object_total (w_total)
    );

    assign m_axis_tdata = {6'd0, w_total, w_idx, w_cy, w_cx};

endmodule

>>> rtl/core/scpc_queue.sv
// Short job queue between the clustering front end and the divider back end.
module scpc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scpc_pkg::t_job i_push_job,
    input  logic           i_pop,
    output scpc_pkg::t_job o_head_job,
    output logic           o_empty,
    output logic           o_full
);
    import scpc_pkg::*;

    t_job                 r_slot [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueuePtrW:0]   r_fill;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_empty    = (r_fill == '0);
    assign o_full     = (r_fill == (QueuePtrW+1)'(QueueDepth));
    assign o_head_job = r_slot[r_rd_ptr];
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/scpc_front.sv
// Front end: accepts scan points, tracks the open object and queues close jobs and end markers.
module scpc_front #(
    parameter int MAX_OBJECTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [scpc_pkg::CoordW-1:0]   i_point_x,
    input  logic [scpc_pkg::CoordW-1:0]   i_point_y,
    input  logic                          i_has_point,
    input  logic                          i_last_in_scan,
    input  logic [scpc_pkg::DistW-1:0]    i_join_distance,
    input  logic                          i_q_full,
    output logic                          o_push,
    output scpc_pkg::t_job                o_push_job
);
    import scpc_pkg::*;

    localparam int GivenW = $clog2(MAX_OBJECTS);
    localparam logic [GivenW-1:0] GivenLimit = GivenW'(MAX_OBJECTS - 1);

    logic [CoordW-1:0] r_seed_x, n_seed_x;
    logic [CoordW-1:0] r_seed_y, n_seed_y;
    logic [SumW-1:0]   r_sum_x, n_sum_x;
    logic [SumW-1:0]   r_sum_y, n_sum_y;
    logic [CountW-1:0] r_count, n_count;
    logic              r_open, n_open;
    logic [GivenW-1:0] r_given, n_given;
    logic              r_pend;
    logic [IdxW-1:0]   r_pend_total;

    logic              w_accept;
    logic [CoordW-1:0] w_dx;
    logic [CoordW-1:0] w_dy;
    logic [DistW-1:0]  w_dist;
    logic              w_near;
    logic              w_far;
    logic              w_due_ok;
    logic              w_due_far;
    logic              w_due_last;
    logic              w_due;
    logic [GivenW-1:0] w_given_after;
    t_job              w_job0;
    t_job              w_marker;

    assign o_ready  = !r_pend && !i_q_full;
    assign w_accept = i_valid && o_ready;

    assign w_dx   = (i_point_x > r_seed_x) ? (i_point_x - r_seed_x) : (r_seed_x - i_point_x);
    assign w_dy   = (i_point_y > r_seed_y) ? (i_point_y - r_seed_y) : (r_seed_y - i_point_y);
    assign w_dist = DistW'(w_dx) + DistW'(w_dy);
    assign w_near = (w_dist <= i_join_distance);
    assign w_far  = i_has_point && r_open && !w_near;

    // State after the point itself, before any close caused by the scan end
    always_comb begin
        n_seed_x = r_seed_x;
        n_seed_y = r_seed_y;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_count  = r_count;
        n_open   = r_open;
        if (i_has_point) begin
            if (!r_open || !w_near) begin
                n_seed_x = i_point_x;
                n_seed_y = i_point_y;
                n_sum_x  = SumW'(i_point_x);
                n_sum_y  = SumW'(i_point_y);
                n_count  = CountW'(1);
                n_open   = 1'b1;
            end else if (r_count < CountMax) begin
                n_sum_x = r_sum_x + SumW'(i_point_x);
                n_sum_y = r_sum_y + SumW'(i_point_y);
                n_count = r_count + 1'b1;
            end
        end
    end

    assign w_due_ok      = (r_given < GivenLimit);
    assign w_due_far     = w_far && (r_count > MinMembers) && w_due_ok;
    assign w_due_last    = i_last_in_scan && !w_far && n_open && (n_count > MinMembers)
                           && w_due_ok;
    assign w_due         = w_due_far || w_due_last;
    assign w_given_after = r_given + GivenW'(w_due);

    always_comb begin
        w_marker           = '0;
        w_marker.is_marker = 1'b1;
        w_marker.total     = IdxW'(w_given_after);

        w_job0           = w_marker;
        if (w_due) begin
            w_job0.is_marker = 1'b0;
            w_job0.index     = IdxW'(r_given);
            w_job0.total     = IdxW'(w_given_after);
            w_job0.count     = w_far ? r_count : n_count;
            w_job0.sum_x     = w_far ? r_sum_x : n_sum_x;
            w_job0.sum_y     = w_far ? r_sum_y : n_sum_y;
        end
    end

    always_comb begin
        n_given = w_given_after;
        if (i_last_in_scan) begin
            n_given = '0;
        end
    end

    always_comb begin
        o_push     = 1'b0;
        o_push_job = w_job0;
        if (r_pend) begin
            o_push               = !i_q_full;
            o_push_job           = '0;
            o_push_job.is_marker = 1'b1;
            o_push_job.total     = r_pend_total;
        end else if (w_accept) begin
            o_push = w_due || i_last_in_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seed_x <= n_seed_x;
            r_seed_y <= n_seed_y;
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_count  <= n_count;
        end
        if (w_accept && w_due && i_last_in_scan) begin
            r_pend_total <= IdxW'(w_given_after);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_given <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_open  <= n_open && !i_last_in_scan;
                r_given <= n_given;
                r_pend  <= w_due && i_last_in_scan;
            end else if (r_pend && !i_q_full) begin
                r_pend <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/scpc_back.sv
// Back end: divides coordinate sums by member count and drives the result register.
module scpc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scpc_pkg::t_job               i_head_job,
    input  logic                         i_q_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [scpc_pkg::CoordW-1:0]  o_centroid_x,
    output logic [scpc_pkg::CoordW-1:0]  o_centroid_y,
    output logic [scpc_pkg::IdxW-1:0]    o_object_index,
    output logic                         o_object_valid,
    output logic                         o_scan_done,
    output logic [scpc_pkg::IdxW-1:0]    o_object_total
);
    import scpc_pkg::*;

    t_back_state        r_state, n_state;
    t_job               r_job;
    logic [SumW-1:0]    r_qx;
    logic [SumW-1:0]    r_qy;
    logic [CountW-1:0]  r_rx;
    logic [CountW-1:0]  r_ry;
    logic [DivCntW-1:0] r_cnt;

    logic               r_out_valid;
    logic [CoordW-1:0]  r_out_cx;
    logic [CoordW-1:0]  r_out_cy;
    logic [IdxW-1:0]    r_out_idx;
    logic               r_out_obj;
    logic               r_out_done;
    logic [IdxW-1:0]    r_out_total;

    logic               w_slot_free;
    logic               w_step;
    logic               w_load;
    logic [CountW:0]    w_tx;
    logic [CountW:0]    w_ty;
    logic               w_gex;
    logic               w_gey;

    assign w_slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_head_job.is_marker ? B_EMIT : B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == '0) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (w_slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_step = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            B_IDLE:  o_pop  = !i_q_empty;
            B_DIV:   w_step = 1'b1;
            B_EMIT:  w_load = w_slot_free;
            default: o_pop  = 1'b0;
        endcase
    end

    // Restoring division, one quotient bit per cycle for both coordinates
    assign w_tx  = {r_rx, r_qx[SumW-1]};
    assign w_ty  = {r_ry, r_qy[SumW-1]};
    assign w_gex = (w_tx >= {1'b0, r_job.count});
    assign w_gey = (w_ty >= {1'b0, r_job.count});

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head_job;
            r_qx  <= i_head_job.sum_x;
            r_qy  <= i_head_job.sum_y;
            r_rx  <= '0;
            r_ry  <= '0;
            r_cnt <= DivCntW'(DivSteps - 1);
        end else if (w_step) begin
            r_rx  <= w_gex ? CountW'(w_tx - {1'b0, r_job.count}) : CountW'(w_tx);
            r_ry  <= w_gey ? CountW'(w_ty - {1'b0, r_job.count}) : CountW'(w_ty);
            r_qx  <= {r_qx[SumW-2:0], w_gex};
            r_qy  <= {r_qy[SumW-2:0], w_gey};
            r_cnt <= r_cnt - 1'b1;
        end
        if (w_load) begin
            r_out_cx    <= r_job.is_marker ? '0 : r_qx[CoordW-1:0];
            r_out_cy    <= r_job.is_marker ? '0 : r_qy[CoordW-1:0];
            r_out_idx   <= r_job.is_marker ? '0 : r_job.index;
            r_out_obj   <= !r_job.is_marker;
            r_out_done  <= r_job.is_marker;
            r_out_total <= r_job.total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_centroid_x   = r_out_cx;
    assign o_centroid_y   = r_out_cy;
    assign o_object_index = r_out_idx;
    assign o_object_valid = r_out_obj;
    assign o_scan_done    = r_out_done;
    assign o_object_total = r_out_total;

endmodule

>>> tb/sv/scan_point_cluster_centroids_test.sv
// Testbench for scan_point_cluster_centroids: directed and random point streams against a cluster predictor.
`timescale 1ns / 100ps

module scan_point_cluster_centroids_test;
    import scpc_pkg::*;

    localparam int MaxObjects = 8;
    localparam logic [2:0] JoinDistanceAddr = 3'd0;
    localparam int CoordMax = (1 << CoordW) - 1;
    localparam int DistMax = (1 << DistW) - 1;
    localparam int IdlePct = 18;
    localparam int HoldCycles = 400;
    localparam int SettleCycles = 64;
    localparam int LongScanLen = 150;

    typedef struct {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              has;
        logic              last;
    } t_point;

    typedef struct {
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [IdxW-1:0]   index;
        logic [IdxW-1:0]   total;
        logic              valid;
        logic              done;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    scan_point_cluster_centroids #(
        .MAX_OBJECTS(MaxObjects)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    t_point  scan_points[$];
    t_report cluster_reports[$];

    // predictor state
    int unsigned reach_mm = 32'(JoinReset);
    int unsigned anchor_x = 0;
    int unsigned anchor_y = 0;
    int unsigned acc_x = 0;
    int unsigned acc_y = 0;
    int unsigned members = 0;
    int unsigned reported = 0;
    bit          cluster_live = 1'b0;

    int  mismatches = 0;
    int  items_queued = 0;
    int  points_taken = 0;
    int  hold_from = -1;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  calm = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("scan_point_cluster_centroids test failed");
        $finish;
    end

    task report_mismatch(input string what);
        if (mismatches < 50) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    task check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic void open_cluster(input int unsigned x, input int unsigned y);
        anchor_x = x;
        anchor_y = y;
        acc_x = x;
        acc_y = y;
        members = 1;
        cluster_live = 1'b1;
    endfunction

    function automatic void close_cluster();
        t_report r;
        if (cluster_live && members > MinMembers && reported < MaxObjects - 1) begin
            r.cx = CoordW'(acc_x / members);
            r.cy = CoordW'(acc_y / members);
            r.index = IdxW'(reported);
            r.valid = 1'b1;
            r.done = 1'b0;
            reported++;
            r.total = IdxW'(reported);
            cluster_reports.push_back(r);
        end
        cluster_live = 1'b0;
    endfunction

    function automatic void take_point(input t_point p);
        int unsigned px;
        int unsigned py;
        int unsigned dx;
        int unsigned dy;
        t_report r;
        px = p.x;
        py = p.y;
        if (p.has) begin
            if (!cluster_live) begin
                open_cluster(px, py);
            end else begin
                dx = px > anchor_x ? px - anchor_x : anchor_x - px;
                dy = py > anchor_y ? py - anchor_y : anchor_y - py;
                if (dx + dy <= reach_mm) begin
                    if (members < CountMax) begin
                        acc_x += px;
                        acc_y += py;
                        members++;
                    end
                end else begin
                    close_cluster();
                    open_cluster(px, py);
                end
            end
        end
        if (p.last) begin
            close_cluster();
            r.cx = '0;
            r.cy = '0;
            r.index = '0;
            r.valid = 1'b0;
            r.done = 1'b1;
            r.total = IdxW'(reported);
            cluster_reports.push_back(r);
            reported = 0;
            cluster_live = 1'b0;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin : feed
        t_point pt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (scan_points.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
                pt = scan_points.pop_front();
                s_axis_tdata <= {4'd0, pt.y, pt.x};
                s_axis_tuser <= pt.has;
                s_axis_tlast <= pt.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && hold_from >= 0 && points_taken >= hold_from) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    // result check first, then prediction for the request taken at this edge
    always @(posedge i_clk) begin : watch
        t_report want;
        t_point  pt;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cluster_reports.size() == 0) begin
                    report_mismatch("result with nothing due");
                end else begin
                    want = cluster_reports.pop_front();
                    check_field("centroid_x", m_axis_tdata[13:0], want.cx);
                    check_field("centroid_y", m_axis_tdata[27:14], want.cy);
                    check_field("object_index", m_axis_tdata[30:28], want.index);
                    check_field("object_total", m_axis_tdata[33:31], want.total);
                    check_field("pad", m_axis_tdata[39:34], 0);
                    check_field("object_valid", m_axis_tuser, want.valid);
                    check_field("scan_done", m_axis_tlast, want.done);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pt.x = s_axis_tdata[13:0];
                pt.y = s_axis_tdata[27:14];
                pt.has = s_axis_tuser;
                pt.last = s_axis_tlast;
                take_point(pt);
                points_taken <= points_taken + 1;
            end
        end
    end

    task automatic queue_item(input int x, input int y, input bit has, input bit last);
        t_point pt;
        pt.x = CoordW'(x);
        pt.y = CoordW'(y);
        pt.has = has;
        pt.last = last;
        scan_points.push_back(pt);
        if (has || last) begin
            items_queued++;
        end
    endtask

    function automatic int clamp_coord(input int v);
        return v < 0 ? 0 : (v > CoordMax ? CoordMax : v);
    endfunction

    // clusters of near points around random seeds, with stray and ignored items mixed in
    task automatic queue_scan(input int reach);
        int clusters;
        int size;
        int sx;
        int sy;
        int d;
        int dx;
        clusters = $urandom_range(0, 12);
        for (int c = 0; c < clusters; c++) begin
            sx = $urandom_range(0, CoordMax);
            sy = $urandom_range(0, CoordMax);
            size = $urandom_range(1, 8);
            queue_item(sx, sy, 1'b1, 1'b0);
            for (int m = 1; m < size; m++) begin
                if ($urandom_range(0, 9) == 0) begin
                    d = reach + $urandom_range(1, 40);
                end else begin
                    d = $urandom_range(0, reach);
                end
                dx = $urandom_range(0, d);
                queue_item(clamp_coord($urandom_range(0, 1) ? sx + dx : sx - dx),
                           clamp_coord($urandom_range(0, 1) ? sy + d - dx : sy - d + dx),
                           1'b1, 1'b0);
                if ($urandom_range(0, 15) == 0) begin
                    queue_item($urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                               1'b0, 1'b0);
                end
            end
        end
        queue_item($urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                   1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic queue_scans(input int count);
        int stop;
        stop = items_queued + count;
        while (items_queued < stop) begin
            queue_scan(reach_mm);
        end
    endtask

    task automatic write_reach(input int unsigned value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= JoinDistanceAddr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reach_mm = value & DistMax;
    endtask

    task automatic drain();
        while (!(scan_points.size() == 0 && !s_axis_tvalid && cluster_reports.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset distance of 150
        queue_item(0, 0, 1'b0, 1'b1);
        queue_item(123, 456, 1'b0, 1'b0);
        queue_item(CoordMax, CoordMax, 1'b1, 1'b0);
        queue_item(CoordMax, CoordMax, 1'b1, 1'b0);
        queue_item(CoordMax, CoordMax, 1'b1, 1'b0);
        queue_item(0, 0, 1'b1, 1'b0);
        queue_item(0, 0, 1'b1, 1'b0);
        queue_item(150, 0, 1'b1, 1'b0);
        queue_item(0, 151, 1'b1, 1'b0);
        queue_item(0, 152, 1'b0, 1'b1);
        queue_item(5, 5, 1'b1, 1'b0);
        queue_item(5, 5, 1'b1, 1'b0);
        queue_item(9000, 9000, 1'b1, 1'b0);
        queue_item(9000, 9000, 1'b1, 1'b0);
        queue_item(9001, 9002, 1'b1, 1'b0);
        queue_item(20, 20, 1'b1, 1'b1);
        queue_item(7, 7, 1'b1, 1'b0);
        queue_item(7, 7, 1'b1, 1'b0);
        queue_item(7, 7, 1'b1, 1'b0);
        queue_item(7, 7, 1'b1, 1'b1);
        drain();

        // exact matches only
        write_reach(0);
        queue_scans(200);
        drain();

        // everything joins; one long scan at full coordinate range, then random scans
        write_reach(DistMax);
        for (int i = 0; i < LongScanLen; i++) begin
            queue_item($urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                       1'b1, i == LongScanLen - 1);
        end
        queue_scans(100);
        drain();

        // long output stall while requests keep coming
        write_reach($urandom_range(1, 2000));
        hold_from <= points_taken + 80;
        queue_scans(250);
        drain();

        // no idling on either side
        write_reach(32'(JoinReset));
        calm <= 1'b1;
        queue_scans(250);
        drain();
        calm <= 1'b0;

        write_reach($urandom_range(1, 40));
        queue_scans(200);
        drain();

        if (mismatches == 0) begin
            $display("scan_point_cluster_centroids test passed");
        end else begin
            $display("scan_point_cluster_centroids test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/scpc_pkg.sv
rtl/core/scpc_queue.sv
rtl/core/scpc_front.sv
rtl/core/scpc_back.sv
rtl/core/scan_point_cluster_centroids.sv
tb/sv/scan_point_cluster_centroids_test.sv
